// ===== rtl/ncap_pkg.sv =====
// Package for the NMEA sentence capture unit.
// Holds the command codes, the character constants, the header strings and the
// input and result transaction types. It depends on nothing else.
package ncap_pkg;

  // Default depth of the sentence store, in bytes.
  localparam int unsigned STORE_DEPTH_DEF = 110;

  // Field widths fixed by the interface.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned HDR_LEN = 5;

  // Characters that steer the capture.
  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_END   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // Saturation limit of a decimal field.
  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

  // The comma counter saturates here, and the two fields of interest follow
  // these commas.
  localparam logic [3:0] COMMA_MAX = 4'd15;
  localparam logic [3:0] COMMA_FIX = 4'd6;
  localparam logic [3:0] COMMA_SAT = 4'd7;

  // Sentence headers, compared one byte at a time.
  localparam logic [BYTE_W-1:0] GGA_HDR [HDR_LEN] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam logic [BYTE_W-1:0] RMC_HDR [HDR_LEN] = '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  // Result kinds.
  typedef enum logic {
    KIND_END  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // Sentence types reported when a sentence ends.
  typedef enum logic [TYPE_W-1:0] {
    TYPE_OTHER = 2'd0,
    TYPE_GGA   = 2'd1,
    TYPE_RMC   = 2'd2
  } stype_e;

  // One input transaction.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] read_index;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic               result_kind;
    logic [TYPE_W-1:0]  sentence_type;
    logic [VALUE_W-1:0] fix_quality;
    logic [VALUE_W-1:0] satellites_used;
    logic               rmc_pending;
    logic [BYTE_W-1:0]  read_data;
    logic [LEN_W-1:0]   sentence_length;
  } out_item_t;

endpackage

// ===== rtl/nmea_sentence_capture_unit.sv =====
// NMEA sentence capture unit: top level and only module.
// Depends on ncap_pkg for commands, character constants and transaction types.
//
// Usage: the input channel carries one command per transaction: a received
// serial byte, a release of a pending RMC sentence, or a read of the sentence
// store. A '$' starts capture; following bytes fill the store until '*' or
// until the store is full. A '*' produces one result carrying the sentence
// type, the latest GGA fix quality and satellite count, the pending flag and
// the captured length. A store read produces one result with the stored byte.
// Release and ordinary bytes produce no result.
// A result is registered: it appears on the output in the cycle after its input
// transaction is accepted. One input transaction is taken per cycle while the
// input is not stalled; all state updates run in one combinational step between
// the input port and the result register, and the store is one memory with a
// write port and a registered read port.
// Reset clears all control state at once; the store keeps whatever it held.
// When the receiver stalls, the result register holds, and the input stalls
// only while that register is full and not being taken.
module nmea_sentence_capture_unit #(
  parameter int unsigned STORE_DEPTH = ncap_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ncap_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ncap_pkg::out_item_t out_data_o
);
  import ncap_pkg::*;

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);

  // Control and field state.
  logic               cap_q, cap_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         hdr_q, hdr_d;
  logic [3:0]         comma_q, comma_d;
  logic               prev_comma_q, prev_comma_d;
  logic [VALUE_W-1:0] fa_val_q [2];
  logic [VALUE_W-1:0] fa_val_d [2];
  logic [1:0]         fa_seen_q, fa_seen_d;
  logic [1:0]         run_q, run_d;
  logic [VALUE_W-1:0] fix_q, fix_d;
  logic [VALUE_W-1:0] sat_q, sat_d;
  logic               pend_q, pend_d;

  // Result register.
  logic               out_valid_q;
  logic               kind_q, kind_d;
  logic [TYPE_W-1:0]  type_q, type_d;
  logic [VALUE_W-1:0] ofix_q, osat_q;
  logic               opend_q;
  logic [LEN_W-1:0]   len_q;
  logic [BYTE_W-1:0]  rd_q;

  // Sentence store.
  logic [BYTE_W-1:0]  mem [STORE_DEPTH];

  logic               in_acc;
  logic               emit;
  logic               wr_en;
  logic               rd_hit;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [AW+INDEX_W-1:0] rd_addr_ext;
  logic [CNT_W+LEN_W-1:0] len_ext;
  logic [BYTE_W-1:0]  c;
  logic [CNT_W-1:0]   pos;
  logic               digit;
  logic               field_start;
  logic               fsel;
  logic [3:0]         dval;
  logic [VALUE_W+3:0] prod;
  logic [VALUE_W-1:0] fnext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Byte classification and the decimal step for the selected field.
  assign c     = in_data_i.data_byte;
  assign pos   = cnt_q;
  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dval  = 4'(c - CH_ZERO);
  assign fsel  = (comma_q == COMMA_SAT);
  assign prod  = {4'd0, fa_val_q[fsel]} * 20'd10 + {16'd0, dval};
  assign fnext = (prod > {4'd0, VALUE_MAX}) ? VALUE_MAX : prod[VALUE_W-1:0];
  assign field_start = (pos != '0) && prev_comma_q;

  // Next state and result contents for one input transaction.
  always_comb begin
    cap_d        = cap_q;
    cnt_d        = cnt_q;
    hdr_d        = hdr_q;
    comma_d      = comma_q;
    prev_comma_d = prev_comma_q;
    fa_val_d     = fa_val_q;
    fa_seen_d    = fa_seen_q;
    run_d        = run_q;
    fix_d        = fix_q;
    sat_d        = sat_q;
    pend_d       = pend_q;
    emit         = 1'b0;
    wr_en        = 1'b0;
    kind_d       = KIND_END;
    type_d       = TYPE_OTHER;
    case (cmd_e'(in_data_i.command))
      CMD_RELEASE: begin
        pend_d = 1'b0;
      end
      CMD_READ: begin
        emit   = 1'b1;
        kind_d = KIND_READ;
      end
      CMD_BYTE: begin
        if (!pend_q) begin
          if (!cap_q) begin
            if (c == CH_START) begin
              cap_d     = 1'b1;
              cnt_d     = '0;
              hdr_d     = 2'b11;
              comma_d   = '0;
              fa_val_d  = '{'0, '0};
              fa_seen_d = '0;
              run_d     = '0;
            end
          end else begin
            wr_en        = (32'(pos) < STORE_DEPTH);
            cnt_d        = pos + 1'b1;
            prev_comma_d = (c == CH_COMMA);
            if (32'(cnt_d) >= STORE_DEPTH) begin
              cap_d = 1'b0;
            end
            // Header match over the first five bytes.
            if (32'(pos) < HDR_LEN) begin
              if (c != GGA_HDR[pos[2:0]]) hdr_d[0] = 1'b0;
              if (c != RMC_HDR[pos[2:0]]) hdr_d[1] = 1'b0;
            end
            // Leading digit run of the fix or satellite field.
            if ((comma_q == COMMA_FIX) || (comma_q == COMMA_SAT)) begin
              if (field_start) begin
                if (digit) begin
                  fa_val_d[fsel]  = {12'd0, dval};
                  fa_seen_d[fsel] = 1'b1;
                  run_d[fsel]     = 1'b1;
                end
              end else if (run_q[fsel]) begin
                if (!digit) begin
                  run_d[fsel] = 1'b0;
                end else begin
                  fa_val_d[fsel]  = fnext;
                  fa_seen_d[fsel] = 1'b1;
                end
              end
            end
            if ((c == CH_COMMA) && (comma_q < COMMA_MAX)) begin
              comma_d = comma_q + 1'b1;
            end
            // End of sentence.
            if (c == CH_END) begin
              cap_d = 1'b0;
              emit  = 1'b1;
              if (hdr_q[0] && hdr_d[0]) begin
                type_d = TYPE_GGA;
                if (fa_seen_d[0]) fix_d = fa_val_d[0];
                if (fa_seen_d[1]) sat_d = fa_val_d[1];
              end else if (hdr_d[1]) begin
                type_d = TYPE_RMC;
                pend_d = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Address and length conversions.
  assign wr_addr     = pos[AW-1:0];
  assign rd_addr_ext = {{AW{1'b0}}, in_data_i.read_index};
  assign rd_addr     = rd_addr_ext[AW-1:0];
  assign rd_hit      = (32'(in_data_i.read_index) < STORE_DEPTH);
  assign len_ext     = {{LEN_W{1'b0}}, cnt_d};

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= 1'b0;
      cnt_q        <= '0;
      hdr_q        <= '0;
      comma_q      <= '0;
      prev_comma_q <= 1'b0;
      fa_val_q     <= '{'0, '0};
      fa_seen_q    <= '0;
      run_q        <= '0;
      fix_q        <= '0;
      sat_q        <= '0;
      pend_q       <= 1'b0;
    end else if (in_acc) begin
      cap_q        <= cap_d;
      cnt_q        <= cnt_d;
      hdr_q        <= hdr_d;
      comma_q      <= comma_d;
      prev_comma_q <= prev_comma_d;
      fa_val_q     <= fa_val_d;
      fa_seen_q    <= fa_seen_d;
      run_q        <= run_d;
      fix_q        <= fix_d;
      sat_q        <= sat_d;
      pend_q       <= pend_d;
    end
  end

  // Result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      kind_q  <= kind_d;
      type_q  <= type_d;
      ofix_q  <= fix_d;
      osat_q  <= sat_d;
      opend_q <= pend_d;
      len_q   <= len_ext[LEN_W-1:0];
    end
  end

  // Sentence store write port.
  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      mem[wr_addr] <= c;
    end
  end

  // Sentence store registered read port; an end-of-sentence result reads zero.
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      if ((kind_d == KIND_READ) && rd_hit) begin
        rd_q <= mem[rd_addr];
      end else begin
        rd_q <= '0;
      end
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_data_o.result_kind     = kind_q;
  assign out_data_o.sentence_type   = type_q;
  assign out_data_o.fix_quality     = ofix_q;
  assign out_data_o.satellites_used = osat_q;
  assign out_data_o.rmc_pending     = opend_q;
  assign out_data_o.read_data       = rd_q;
  assign out_data_o.sentence_length = len_q;

  // A pending RMC sentence always leaves the block not capturing.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !cap_q)
    else $error("pending flag set while capturing");

  // The byte count never passes the store depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= STORE_DEPTH)
    else $error("byte count beyond store depth");

  // A store read result carries no sentence type.
  a_read_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.result_kind == KIND_READ)) |->
      (out_data_o.sentence_type == TYPE_OTHER))
    else $error("store read result with a sentence type");

  // An end-of-sentence result carries zero read data.
  a_end_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.result_kind == KIND_END)) |->
      (out_data_o.read_data == '0))
    else $error("end-of-sentence result with read data");

  // An RMC end result always reports the pending flag as set.
  a_rmc_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.sentence_type == TYPE_RMC)) |->
      out_data_o.rmc_pending)
    else $error("RMC result without pending flag");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for nmea_sentence_capture_unit.
// Holds a scoreboard class with a cycle-free predictor of the capture unit, and the
// tasks that drive it. Depends on ncap_pkg and the unit's RTL.
module testbench;
  import ncap_pkg::*;

  // Command code with no meaning to the unit; it must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned ITEMS_TARGET = 1625;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Predicts the capture unit's results and compares them with the ones it emits.
  class capture_scoreboard;
    out_item_t   awaited[$];
    int unsigned errors;
    int unsigned high_water;
    bit          in_sentence;
    int unsigned byte_cnt;
    logic [7:0]  store [STORE_DEPTH_DEF];
    bit [1:0]    header_ok;
    int unsigned commas;
    int unsigned fld_value [2];
    bit          fld_seen [2];
    bit          fld_open [2];
    logic [15:0] fix_q;
    logic [15:0] sat_n;
    bit          rmc_hold;

    function new();
      errors = 0;
      high_water = 0;
      in_sentence = 1'b0;
      byte_cnt = 0;
      header_ok = '0;
      commas = 0;
      fix_q = '0;
      sat_n = '0;
      rmc_hold = 1'b0;
      for (int i = 0; i < 2; i++) begin
        fld_value[i] = 0;
        fld_seen[i] = 1'b0;
        fld_open[i] = 1'b0;
      end
      for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
        store[i] = '0;
      end
    endfunction

    // A field's value is its leading run of digits, saturated at the 16-bit limit.
    function void field_char_step(int k, logic [7:0] c, bit at_start);
      bit digit;
      int unsigned v;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (at_start) begin
        if (digit) begin
          fld_value[k] = c - CH_ZERO;
          fld_seen[k] = 1'b1;
          fld_open[k] = 1'b1;
        end
        return;
      end
      if (!fld_open[k]) return;
      if (!digit) begin
        fld_open[k] = 1'b0;
        return;
      end
      v = fld_value[k] * 10 + (c - CH_ZERO);
      fld_value[k] = (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    function out_item_t make_result(kind_e kind, stype_e st, logic [7:0] data);
      out_item_t r;
      r.result_kind = kind;
      r.sentence_type = st;
      r.fix_quality = fix_q;
      r.satellites_used = sat_n;
      r.rmc_pending = rmc_hold;
      r.read_data = data;
      r.sentence_length = LEN_W'(byte_cnt);
      return r;
    endfunction

    // One received character: hunt for the start mark, or capture and parse.
    function void take_byte(logic [7:0] c);
      int unsigned pos;
      bit at_start;
      stype_e st;
      if (!in_sentence) begin
        if (c == CH_START) begin
          in_sentence = 1'b1;
          byte_cnt = 0;
          header_ok = 2'b11;
          commas = 0;
          for (int i = 0; i < 2; i++) begin
            fld_value[i] = 0;
            fld_seen[i] = 1'b0;
            fld_open[i] = 1'b0;
          end
        end
        return;
      end
      pos = byte_cnt;
      store[pos] = c;
      if (pos + 1 > high_water) high_water = pos + 1;
      byte_cnt = pos + 1;
      // The byte that fills the store is still checked for the end mark below.
      if (byte_cnt >= STORE_DEPTH_DEF) in_sentence = 1'b0;
      if (pos < HDR_LEN) begin
        if (c != GGA_HDR[pos]) header_ok[0] = 1'b0;
        if (c != RMC_HDR[pos]) header_ok[1] = 1'b0;
      end
      at_start = (pos > 0) && (store[pos-1] == CH_COMMA);
      if (commas == COMMA_FIX) field_char_step(0, c, at_start);
      else if (commas == COMMA_SAT) field_char_step(1, c, at_start);
      if (c == CH_COMMA && commas < COMMA_MAX) commas++;
      if (c == CH_END) begin
        in_sentence = 1'b0;
        st = TYPE_OTHER;
        if (header_ok[0]) begin
          st = TYPE_GGA;
          if (fld_seen[0]) fix_q = VALUE_W'(fld_value[0]);
          if (fld_seen[1]) sat_n = VALUE_W'(fld_value[1]);
        end else if (header_ok[1]) begin
          st = TYPE_RMC;
          rmc_hold = 1'b1;
        end
        awaited.push_back(make_result(KIND_END, st, '0));
      end
    endfunction

    // Called for every accepted input transaction.
    function void note_item(in_item_t it);
      case (it.command)
        CMD_RELEASE: rmc_hold = 1'b0;
        CMD_READ: begin
          awaited.push_back(make_result(KIND_READ, TYPE_OTHER,
            (it.read_index < STORE_DEPTH_DEF) ? store[it.read_index] : 8'h00));
        end
        CMD_BYTE: begin
          if (!rmc_hold) take_byte(it.data_byte);
        end
        default: ;
      endcase
    endfunction

    // Print one line per mismatch and count it.
    task report(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch in %s: got %0d, want %0d", $time, what, got, want);
      errors++;
    endtask

    // Called for every accepted result transaction.
    task check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report("result_kind of a result with nothing outstanding", got.result_kind, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.result_kind !== want.result_kind)
        report("result_kind", got.result_kind, want.result_kind);
      if (got.sentence_type !== want.sentence_type)
        report("sentence_type", got.sentence_type, want.sentence_type);
      if (got.fix_quality !== want.fix_quality)
        report("fix_quality", got.fix_quality, want.fix_quality);
      if (got.satellites_used !== want.satellites_used)
        report("satellites_used", got.satellites_used, want.satellites_used);
      if (got.rmc_pending !== want.rmc_pending)
        report("rmc_pending", got.rmc_pending, want.rmc_pending);
      if (got.read_data !== want.read_data)
        report("read_data", got.read_data, want.read_data);
      if (got.sentence_length !== want.sentence_length)
        report("sentence_length", got.sentence_length, want.sentence_length);
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  capture_scoreboard capture_sb;
  logic [7:0]  line_q[$];
  int unsigned items_sent;
  int unsigned calm_in;

  nmea_sentence_capture_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction, hold it until taken, then sometimes idle for a while.
  task automatic send_fields(logic [CMD_W-1:0] cmd, logic [7:0] data, logic [6:0] idx);
    in_item_t it;
    int unsigned gap;
    it.command = cmd;
    it.data_byte = data;
    it.read_index = idx;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    capture_sb.note_item(it);
    items_sent++;
    if (calm_in > 0) begin
      calm_in--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 149) == 0) calm_in = 50;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] c);
    send_fields(CMD_BYTE, c, 7'($urandom_range(0, 127)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Reads touch only entries already written, or indexes past the store.
  task automatic send_read();
    logic [6:0] idx;
    if (capture_sb.high_water > 0 && $urandom_range(0, 4) != 0)
      idx = 7'($urandom_range(0, capture_sb.high_water - 1));
    else
      idx = 7'($urandom_range(STORE_DEPTH_DEF, 127));
    send_fields(CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_other(logic [CMD_W-1:0] cmd);
    send_fields(cmd, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  function automatic logic [7:0] field_char();
    return 8'($urandom_range(8'h2D, 8'h5A));
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] letter_char();
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
  endfunction

  function automatic void add_field();
    int unsigned n;
    n = $urandom_range(0, 4);
    repeat (n) line_q.push_back(field_char());
  endfunction

  function automatic void add_digits(int unsigned lo, int unsigned hi);
    int unsigned n;
    n = $urandom_range(lo, hi);
    repeat (n) line_q.push_back(digit_char());
  endfunction

  // Numeric field: empty, short, long enough that it may saturate, or broken by a letter.
  function automatic void add_number();
    case ($urandom_range(0, 4))
      0: ;
      1: add_digits(1, 3);
      2: add_digits(5, 7);
      3: begin
        line_q.push_back(letter_char());
        add_digits(1, 2);
      end
      default: begin
        add_digits(1, 2);
        line_q.push_back(letter_char());
        add_digits(1, 2);
      end
    endcase
  endfunction

  // Checksum and line end, seen by the unit while it hunts for the next start.
  function automatic void add_tail();
    string hex;
    hex = "0123456789ABCDEF";
    line_q.push_back(hex[$urandom_range(0, 15)]);
    line_q.push_back(hex[$urandom_range(0, 15)]);
    line_q.push_back(8'h0D);
    line_q.push_back(8'h0A);
  endfunction

  function automatic void add_fields(int unsigned n);
    for (int k = 1; k <= n; k++) begin
      line_q.push_back(CH_COMMA);
      if (k == COMMA_FIX || k == COMMA_SAT) add_number();
      else add_field();
    end
  endfunction

  // Send the line, sprinkling reads and other commands between its characters.
  task automatic send_line();
    int unsigned r;
    for (int i = 0; i < line_q.size(); i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_read();
      else if (r == 4) send_other(CMD_RELEASE);
      else if (r == 5) send_other(CMD_UNUSED);
      send_byte(line_q[i]);
    end
  endtask

  // Build one random sentence, mostly well formed, and send it.
  task automatic send_sentence();
    int unsigned r;
    int unsigned k;
    bit needs_release;
    needs_release = 1'b0;
    line_q.delete();
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // Position fix sentence, sometimes cut short, at times before its numeric fields.
      add_text("$GPGGA");
      add_fields(($urandom_range(0, 3) == 0) ? $urandom_range(3, 13) : 14);
      line_q.push_back(CH_END);
      add_tail();
    end else if (r < 60) begin
      // Recommended minimum sentence; bytes after it are dropped until release.
      add_text("$GPRMC");
      add_fields($urandom_range(2, 11));
      line_q.push_back(CH_END);
      add_tail();
      repeat ($urandom_range(0, 6)) line_q.push_back(8'($urandom_range(0, 255)));
      needs_release = 1'b1;
    end else if (r < 72) begin
      // Header that may differ from a known one in a single place.
      add_text(($urandom_range(0, 1) == 0) ? "$GPGGA" : "$GPRMC");
      line_q[1 + $urandom_range(0, HDR_LEN - 1)] = letter_char();
      add_fields(14);
      line_q.push_back(CH_END);
      add_tail();
    end else if (r < 80) begin
      // Sentence too short to hold a header.
      line_q.push_back(CH_START);
      k = $urandom_range(0, HDR_LEN - 1);
      for (int i = 0; i < k; i++) begin
        line_q.push_back(($urandom_range(0, 1) == 0) ? GGA_HDR[i] : RMC_HDR[i]);
      end
      line_q.push_back(CH_END);
      add_tail();
    end else if (r < 88) begin
      // Fill the store; the filling byte is either the end mark or not.
      add_text("$GPGGA");
      while (line_q.size() < STORE_DEPTH_DEF) begin
        line_q.push_back(($urandom_range(0, 4) == 0) ? CH_COMMA : field_char());
      end
      if ($urandom_range(0, 1) == 0) begin
        line_q.push_back(CH_END);
      end else begin
        repeat ($urandom_range(1, 5)) line_q.push_back(field_char());
        line_q.push_back(CH_END);
      end
      add_tail();
    end else if (r < 94) begin
      // More commas than the counter holds.
      add_text("$GPGGA");
      repeat (20) begin
        line_q.push_back(CH_COMMA);
        add_digits(0, 2);
      end
      line_q.push_back(CH_END);
      add_tail();
    end else begin
      // Line noise of any byte value.
      repeat ($urandom_range(5, 20)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    send_line();
    if (needs_release) send_other(CMD_RELEASE);
  endtask

  // Main stimulus: reset, directed items, random sentences, then drain.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    items_sent = 0;
    calm_in = 0;
    capture_sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(CMD_UNUSED, 8'hFF, 7'h7F);
    send_fields(CMD_BYTE, 8'h00, 7'h00);
    send_fields(CMD_BYTE, 8'hFF, 7'h7F);
    send_fields(CMD_READ, 8'h00, 7'h7F);
    send_fields(CMD_RELEASE, 8'h00, 7'h00);
    send_text("$GPGGA,,,,,,9,7*");
    send_fields(CMD_READ, 8'hFF, 7'd0);
    send_fields(CMD_READ, 8'h00, 7'd14);
    send_text("$*");

    while (items_sent < ITEMS_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_read();
        3: send_other(CMD_RELEASE);
        4: send_other(CMD_UNUSED);
        default: ;
      endcase
      send_sentence();
    end
    in_valid_i <= 1'b0;

    while (capture_sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (capture_sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and two long hold-offs.
  initial begin
    int unsigned len;
    int unsigned rx_cycles;
    int unsigned holds;
    bit stall_turn;
    out_stall_i = 1'b0;
    rx_cycles = 0;
    holds = 0;
    stall_turn = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds < 2 && rx_cycles >= ((holds == 0) ? 150 : 2500)) begin
        out_stall_i <= 1'b1;
        len = LONG_HOLD;
        holds++;
      end else if (stall_turn) begin
        len = pick_gap();
        if (len > 0) out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        len = ($urandom_range(0, 19) == 0) ? 60 : $urandom_range(1, 5);
      end
      stall_turn = !stall_turn;
      repeat (len) @(posedge clk_i);
      rx_cycles += len;
    end
  end

  // Every result taken by the receiver is checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) capture_sb.check_result(out_data_o);
  end

  // Guard against a hang.
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ncap_pkg.sv
rtl/nmea_sentence_capture_unit.sv
test/testbench.sv
